[hw/rtl/sliding_median_filter_assert.svh]
// Assertion macros for the sliding median filter.
`ifndef SLIDING_MEDIAN_FILTER_ASSERT_SVH
`define SLIDING_MEDIAN_FILTER_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define SMF_ASSERT_IMPL(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("smf check failed");

// antecedent implies consequent in the next cycle
`define SMF_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("smf check failed");

`endif

[hw/rtl/smf_pkg.sv]
`default_nettype none

package smf_pkg;

   localparam int MAX_WINDOW = 32;
   localparam int SAMPLE_W   = 16;
   localparam int WSIZE_W    = 6;
   localparam int TAP_IDX_W  = 5;
   localparam int CAND_W     = 6;
   localparam int D_W        = 5;
   localparam int SEEN_W     = 6;
   localparam logic [SEEN_W-1:0] SEEN_MAX = 6'd63;

   typedef struct packed {
      logic accept;
      logic clr_d;
      logic inc_d;
      logic clr_c;
      logic inc_c;
      logic cmp;
      logic load_med;
      logic load_pass;
      logic finish;
   } smf_cmd_type;

   typedef struct packed {
      logic pass_mode;
      logic d_done;
      logic d_skip;
      logic hit;
      logic out_free;
   } smf_status_type;

endpackage

`default_nettype wire

[hw/rtl/sliding_median_filter.sv]
// channel | direction | handshake            | payload
// req     | in        | req_valid/req_stall  | req_sample[15:0], req_last_in
// rsp     | out       | rsp_valid/rsp_stall  | rsp_filtered[15:0], rsp_last_out
// csr     | in        | csr_wr_en            | csr_wr_data[5:0] (window size)
//
// One word per visit to idle; req_stall stays high until all its results are loaded into the result register.
// Window 0/1: the word is passed through. Otherwise each word walks its delay positions,
// skips some and tries up to 33 candidates per result; the last word yields up to 16 results.
// Synchronous active-high reset clears control, sample count and window size;
// the history shift line is not reset. rsp_stall holds the result register and
// pauses the sequencer when a new result is ready.
`default_nettype none

`include "sliding_median_filter_assert.svh"

module sliding_median_filter
   import smf_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                csr_wr_en,
   input  wire logic [WSIZE_W-1:0]  csr_wr_data,
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire logic [SAMPLE_W-1:0] req_sample,
   input  wire logic                req_last_in,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output logic [SAMPLE_W-1:0]      rsp_filtered,
   output logic                     rsp_last_out
);

   smf_cmd_type    cmd;
   smf_status_type status;

   smf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   smf_datapath u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .status       (status),
      .csr_wr_en    (csr_wr_en),
      .csr_wr_data  (csr_wr_data),
      .req_sample   (req_sample),
      .req_last_in  (req_last_in),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_filtered (rsp_filtered),
      .rsp_last_out (rsp_last_out)
   );

   `SMF_ASSERT_IMPL(a_med_load_ok, cmd.load_med, status.hit && status.out_free)
   `SMF_ASSERT_IMPL(a_no_overwrite, cmd.load_med || cmd.load_pass, !(rsp_valid && rsp_stall))
   `SMF_ASSERT_NEXT(a_busy_after_accept, req_valid && !req_stall, req_stall)
   `SMF_ASSERT_IMPL(a_one_load, 1'b1, !(cmd.load_med && cmd.load_pass))

endmodule

`default_nettype wire

[hw/rtl/smf_ctrl.sv]
`default_nettype none

module smf_ctrl
   import smf_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           req_valid,
   output logic                req_stall,
   input  wire smf_status_type status,
   output smf_cmd_type         cmd
);

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_DSEL = 5'b00010,
      ST_CMP  = 5'b00100,
      ST_CNT  = 5'b01000,
      ST_PASS = 5'b10000
   } smf_state_type;

   smf_state_type state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.accept = 1'b1;
               cmd.clr_d  = 1'b1;
               state_in   = ST_DSEL;
            end
         end
         ST_DSEL: begin
            priority if (status.pass_mode) begin
               state_in = ST_PASS;
            end else if (status.d_done) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end else if (status.d_skip) begin
               cmd.inc_d = 1'b1;
            end else begin
               cmd.clr_c = 1'b1;
               state_in  = ST_CMP;
            end
         end
         ST_CMP: begin
            cmd.cmp  = 1'b1;
            state_in = ST_CNT;
         end
         ST_CNT: begin
            if (status.hit) begin
               if (status.out_free) begin
                  cmd.load_med = 1'b1;
                  cmd.inc_d    = 1'b1;
                  state_in     = ST_DSEL;
               end
            end else begin
               cmd.inc_c = 1'b1;
               state_in  = ST_CMP;
            end
         end
         ST_PASS: begin
            if (status.out_free) begin
               cmd.load_pass = 1'b1;
               cmd.finish    = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

[hw/rtl/smf_datapath.sv]
`default_nettype none

module smf_datapath
   import smf_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire smf_cmd_type         cmd,
   output smf_status_type           status,
   input  wire logic                csr_wr_en,
   input  wire logic [WSIZE_W-1:0]  csr_wr_data,
   input  wire logic [SAMPLE_W-1:0] req_sample,
   input  wire logic                req_last_in,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output logic [SAMPLE_W-1:0]      rsp_filtered,
   output logic                     rsp_last_out
);

   logic [SAMPLE_W-1:0] history_ff [MAX_WINDOW];
   logic [SAMPLE_W-1:0] history_in [MAX_WINDOW];
   logic [WSIZE_W-1:0]  window_ff, window_in;
   logic [SEEN_W-1:0]   seen_ff, seen_in;
   logic [SAMPLE_W-1:0] first_ff, first_in;
   logic                last_ff, last_in;
   logic [D_W-1:0]      d_ff, d_in;
   logic [CAND_W-1:0]   c_ff, c_in;
   logic [MAX_WINDOW-1:0] lt_ff, lt_in, le_ff, le_in;
   logic                h0_lt_ff, h0_lt_in, h0_le_ff, h0_le_in;
   logic                f_lt_ff, f_lt_in, f_le_ff, f_le_in;
   logic [SAMPLE_W-1:0] cand_ff, cand_in;
   logic                out_valid_ff, out_valid_in;
   logic [SAMPLE_W-1:0] out_data_ff, out_data_in;
   logic                out_last_ff, out_last_in;

   logic [WSIZE_W-1:0]  w_eff;
   logic [WSIZE_W-2:0]  half;
   logic [WSIZE_W-1:0]  lag;
   logic [WSIZE_W-1:0]  dmax;
   logic [WSIZE_W-1:0]  lim;
   logic [WSIZE_W-1:0]  nfirst;
   logic [SEEN_W:0]     skip_sum;
   logic [SAMPLE_W-1:0] cand_val;
   logic [WSIZE_W-1:0]  less, leq;
   logic                out_free;

   always_comb begin
      w_eff    = (window_ff > WSIZE_W'(MAX_WINDOW)) ? WSIZE_W'(MAX_WINDOW) : window_ff;
      half     = w_eff[WSIZE_W-1:1];
      lag      = w_eff - WSIZE_W'(1) - {1'b0, half};
      dmax     = last_ff ? lag : '0;
      lim      = w_eff - WSIZE_W'(d_ff);
      nfirst   = (lim > seen_ff) ? (lim - seen_ff) : '0;
      skip_sum = (SEEN_W+1)'(d_ff) + {1'b0, seen_ff} - (SEEN_W+1)'(1);
      cand_val = (c_ff == CAND_W'(MAX_WINDOW)) ? first_ff
                                               : history_ff[c_ff[TAP_IDX_W-1:0]];
      less = WSIZE_W'($countones(lt_ff)) + (h0_lt_ff ? WSIZE_W'(d_ff) : '0)
           + (f_lt_ff ? nfirst : '0);
      leq  = WSIZE_W'($countones(le_ff)) + (h0_le_ff ? WSIZE_W'(d_ff) : '0)
           + (f_le_ff ? nfirst : '0);
      out_free = !out_valid_ff || !rsp_stall;

      status.pass_mode = (w_eff <= WSIZE_W'(1));
      status.d_done    = (WSIZE_W'(d_ff) > dmax);
      status.d_skip    = (skip_sum < (SEEN_W+1)'(lag));
      status.hit       = (less <= WSIZE_W'(half)) && (WSIZE_W'(half) < leq);
      status.out_free  = out_free;
   end

   always_comb begin
      history_in = history_ff;
      window_in  = csr_wr_en ? csr_wr_data : window_ff;
      seen_in    = seen_ff;
      first_in   = first_ff;
      last_in    = last_ff;
      if (cmd.accept) begin
         history_in[0] = req_sample;
         for (int t = 1; t < MAX_WINDOW; t++) begin
            history_in[t] = history_ff[t-1];
         end
         if (seen_ff == '0) begin
            first_in = req_sample;
         end
         if (seen_ff < SEEN_MAX) begin
            seen_in = seen_ff + SEEN_W'(1);
         end
         last_in = req_last_in;
      end else if (cmd.finish && last_ff) begin
         seen_in = '0;
      end

      d_in = d_ff;
      if (cmd.clr_d) begin
         d_in = '0;
      end else if (cmd.inc_d) begin
         d_in = d_ff + D_W'(1);
      end

      c_in = c_ff;
      if (cmd.clr_c) begin
         c_in = '0;
      end else if (cmd.inc_c) begin
         c_in = c_ff + CAND_W'(1);
      end
   end

   // per-tap compare of the current candidate against the clamped window
   always_comb begin
      lt_in    = lt_ff;
      le_in    = le_ff;
      h0_lt_in = h0_lt_ff;
      h0_le_in = h0_le_ff;
      f_lt_in  = f_lt_ff;
      f_le_in  = f_le_ff;
      cand_in  = cand_ff;
      if (cmd.cmp) begin
         for (int t = 0; t < MAX_WINDOW; t++) begin
            lt_in[t] = (WSIZE_W'(t) < lim) && (SEEN_W'(t) < seen_ff)
                       && (history_ff[t] < cand_val);
            le_in[t] = (WSIZE_W'(t) < lim) && (SEEN_W'(t) < seen_ff)
                       && (history_ff[t] <= cand_val);
         end
         h0_lt_in = history_ff[0] < cand_val;
         h0_le_in = history_ff[0] <= cand_val;
         f_lt_in  = first_ff < cand_val;
         f_le_in  = first_ff <= cand_val;
         cand_in  = cand_val;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff && rsp_stall;
      out_data_in  = out_data_ff;
      out_last_in  = out_last_ff;
      priority if (cmd.load_med) begin
         out_valid_in = 1'b1;
         out_data_in  = cand_ff;
         out_last_in  = last_ff && (WSIZE_W'(d_ff) == lag);
      end else if (cmd.load_pass) begin
         out_valid_in = 1'b1;
         out_data_in  = history_ff[0];
         out_last_in  = last_ff;
      end
   end

   always_ff @(posedge clock) begin
      history_ff <= history_in;
      lt_ff      <= lt_in;
      le_ff      <= le_in;
      h0_lt_ff   <= h0_lt_in;
      h0_le_ff   <= h0_le_in;
      f_lt_ff    <= f_lt_in;
      f_le_ff    <= f_le_in;
      cand_ff    <= cand_in;
      last_ff    <= last_in;
      out_data_ff <= out_data_in;
      out_last_ff <= out_last_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff    <= '0;
         seen_ff      <= '0;
         first_ff     <= '0;
         d_ff         <= '0;
         c_ff         <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         window_ff    <= window_in;
         seen_ff      <= seen_in;
         first_ff     <= first_in;
         d_ff         <= d_in;
         c_ff         <= c_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp_valid    = out_valid_ff;
   assign rsp_filtered = out_data_ff;
   assign rsp_last_out = out_last_ff;

endmodule

`default_nettype wire
